@@ rtl/flvtsr_pkg.sv @@
// ----------------------------------------------------------------------------
// FLV tag timestamp rewriter package
// Shared constants, parse phases, configuration and result bundle types.
// ----------------------------------------------------------------------------
`default_nettype none

package flvtsr_pkg;

   localparam int HEADER_BYTES      = 9;
   localparam int TIMED_STREAMS     = 2;
   localparam int IDX_W             = 4;
   localparam int PREV_SIZE_BYTES   = 4;
   localparam int DATA_SIZE_BYTES   = 3;
   localparam int TS_LOW_BYTES      = 3;
   localparam int STREAM_ID_BYTES   = 3;
   localparam int MAX_RESULTS       = 5;
   localparam int CNT_W             = 3;
   localparam int PAYLOAD_W         = 25;
   localparam int SIZE_W            = 24;

   localparam logic [7:0] TAG_AUDIO  = 8'd8;
   localparam logic [7:0] TAG_VIDEO  = 8'd9;
   localparam logic [7:0] TAG_SCRIPT = 8'd18;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_STEP   = 2'd2;

   localparam logic [15:0] FWD_LIMIT_RESET  = 16'd1000;
   localparam logic [15:0] BACK_LIMIT_RESET = 16'd5000;
   localparam logic [15:0] GAP_STEP_RESET   = 16'd10;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PREFIX,
      PH_SIZE,
      PH_TS,
      PH_BODY,
      PH_ENDED
   } phase_type;

   typedef struct packed {
      logic [15:0] fwd_limit;
      logic [15:0] back_limit;
      logic [15:0] gap_step;
   } cfg_type;

   // Up to five results produced by one input item; entry 0 goes out first.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [CNT_W-1:0]            count;
      logic                        stream_end;
      logic [31:0]                 final_ts;
   } bundle_type;

endpackage

`default_nettype wire

@@ rtl/flvtsr_rewrite.sv @@
// ----------------------------------------------------------------------------
// FLV timestamp rewrite unit
// Computes the new output timestamp of one timed stream from its history.
// ----------------------------------------------------------------------------
`default_nettype none

module flvtsr_rewrite
   import flvtsr_pkg::*;
(
   input  wire logic [31:0] ts,
   input  wire logic [31:0] last_in,
   input  wire logic [31:0] last_out,
   input  wire logic        first,
   input  wire cfg_type     cfg,
   output logic [31:0]      new_out
);

   logic        forward;
   logic [31:0] step_fwd;
   logic [31:0] step_back;
   logic [31:0] sum_fwd;
   logic [31:0] sum_gap;
   logic [31:0] diff_back;

   // Both step directions and all candidate results are formed in parallel.
   assign forward   = (ts >= last_in);
   assign step_fwd  = ts - last_in;
   assign step_back = last_in - ts;
   assign sum_fwd   = last_out + step_fwd;
   assign sum_gap   = last_out + {16'd0, cfg.gap_step};
   assign diff_back = last_out - step_back;

   always_comb begin
      if (first) begin
         new_out = 32'd0;
      end else if (forward) begin
         new_out = (step_fwd > {16'd0, cfg.fwd_limit}) ? sum_gap : sum_fwd;
      end else if (step_back < {16'd0, cfg.back_limit}) begin
         // A backward step past zero is clamped to 1.
         new_out = (step_back > last_out) ? 32'd1 : diff_back;
      end else begin
         new_out = sum_gap;
      end
   end

endmodule

`default_nettype wire

@@ rtl/flvtsr_parse.sv @@
// ----------------------------------------------------------------------------
// FLV parser
// Tracks the file structure byte by byte and forms the results of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module flvtsr_parse
   import flvtsr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic [7:0] in_byte,
   input  wire logic       start_of_file,
   input  wire cfg_type    cfg,
   output bundle_type      bundle
);

   phase_type              phase_ff, phase_in, cur_phase;
   logic [IDX_W-1:0]       idx_ff, idx_in, cur_idx;
   logic [PAYLOAD_W-1:0]   left_ff, left_in, cur_left, left_dec;
   logic [SIZE_W-1:0]      size_ff, size_in, cur_size, size_shift;
   logic [31:0]            held_ff, held_in, cur_held;
   logic [7:0]             tag_ff, tag_in, cur_tag;
   logic [23:0]            tsacc_ff, tsacc_in, cur_tsacc;
   logic [31:0]            li_ff [TIMED_STREAMS];
   logic [31:0]            li_in [TIMED_STREAMS];
   logic [31:0]            lo_ff [TIMED_STREAMS];
   logic [31:0]            lo_in [TIMED_STREAMS];
   logic [TIMED_STREAMS-1:0] first_ff, first_in;

   logic        type_ok;
   logic        timed;
   logic        sel;
   logic [31:0] ts_full;
   logic [31:0] rw_out;
   logic [31:0] ts_out;

   // A start-of-file byte sees the cleared state and is handled as header byte 0.
   always_comb begin
      cur_phase = start_of_file ? PH_HEADER : phase_ff;
      cur_idx   = start_of_file ? '0 : idx_ff;
      cur_left  = start_of_file ? '0 : left_ff;
      cur_size  = start_of_file ? '0 : size_ff;
      cur_held  = start_of_file ? '0 : held_ff;
      cur_tag   = start_of_file ? '0 : tag_ff;
      cur_tsacc = start_of_file ? '0 : tsacc_ff;
   end

   assign type_ok    = (in_byte == TAG_AUDIO) || (in_byte == TAG_VIDEO) ||
                       (in_byte == TAG_SCRIPT);
   assign timed      = (cur_tag == TAG_AUDIO) || (cur_tag == TAG_VIDEO);
   assign sel        = cur_tag[0];
   assign ts_full    = {in_byte, cur_tsacc};
   assign size_shift = {cur_size[SIZE_W-9:0], in_byte};
   assign left_dec   = (cur_left != '0) ? cur_left - 1'b1 : '0;

   flvtsr_rewrite u_rewrite (
      .ts       (ts_full),
      .last_in  (start_of_file ? 32'd0 : li_ff[sel]),
      .last_out (start_of_file ? 32'd0 : lo_ff[sel]),
      .first    (start_of_file | first_ff[sel]),
      .cfg      (cfg),
      .new_out  (rw_out)
   );

   assign ts_out = timed ? rw_out : 32'd0;

   // Next phase.
   always_comb begin
      phase_in = cur_phase;
      unique case (cur_phase)
         PH_HEADER: begin
            if (cur_idx == IDX_W'(HEADER_BYTES - 1)) begin
               phase_in = PH_PREFIX;
            end
         end
         PH_PREFIX: begin
            if (cur_idx == IDX_W'(PREV_SIZE_BYTES)) begin
               phase_in = type_ok ? PH_SIZE : PH_ENDED;
            end
         end
         PH_SIZE: begin
            if (cur_idx == IDX_W'(DATA_SIZE_BYTES - 1)) begin
               phase_in = PH_TS;
            end
         end
         PH_TS: begin
            if (cur_idx == IDX_W'(TS_LOW_BYTES)) begin
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if (left_dec == '0) begin
               phase_in = PH_PREFIX;
            end
         end
         PH_ENDED: phase_in = PH_ENDED;
         default:  phase_in = PH_HEADER;
      endcase
   end

   // Datapath state.
   always_comb begin
      idx_in   = cur_idx;
      left_in  = cur_left;
      size_in  = cur_size;
      held_in  = cur_held;
      tag_in   = cur_tag;
      tsacc_in = cur_tsacc;
      for (int s = 0; s < TIMED_STREAMS; s++) begin
         li_in[s]    = start_of_file ? 32'd0 : li_ff[s];
         lo_in[s]    = start_of_file ? 32'd0 : lo_ff[s];
         first_in[s] = start_of_file | first_ff[s];
      end
      unique case (cur_phase)
         PH_HEADER: begin
            idx_in = (cur_idx == IDX_W'(HEADER_BYTES - 1)) ? '0 : cur_idx + 1'b1;
         end
         PH_PREFIX: begin
            if (cur_idx != IDX_W'(PREV_SIZE_BYTES)) begin
               held_in = {cur_held[23:0], in_byte};
               idx_in  = cur_idx + 1'b1;
            end else begin
               idx_in = '0;
               tag_in = in_byte;
               if (type_ok) begin
                  held_in = '0;
                  size_in = '0;
               end
            end
         end
         PH_SIZE: begin
            size_in = size_shift;
            if (cur_idx == IDX_W'(DATA_SIZE_BYTES - 1)) begin
               idx_in   = '0;
               left_in  = {1'b0, size_shift} + PAYLOAD_W'(STREAM_ID_BYTES);
               tsacc_in = '0;
            end else begin
               idx_in = cur_idx + 1'b1;
            end
         end
         PH_TS: begin
            if (cur_idx != IDX_W'(TS_LOW_BYTES)) begin
               tsacc_in = {cur_tsacc[15:0], in_byte};
               idx_in   = cur_idx + 1'b1;
            end else begin
               idx_in = '0;
               if (timed) begin
                  li_in[sel]    = ts_full;
                  lo_in[sel]    = rw_out;
                  first_in[sel] = 1'b0;
               end
            end
         end
         PH_BODY: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               idx_in  = '0;
               held_in = '0;
            end
         end
         PH_ENDED: begin
         end
         default: begin
         end
      endcase
   end

   // Results of the current item.
   always_comb begin
      bundle            = '0;
      bundle.bytes[0]   = in_byte;
      unique case (cur_phase)
         PH_HEADER, PH_SIZE, PH_BODY: begin
            bundle.count = CNT_W'(1);
         end
         PH_PREFIX: begin
            if (cur_idx == IDX_W'(PREV_SIZE_BYTES)) begin
               if (type_ok) begin
                  bundle.bytes[0] = cur_held[31:24];
                  bundle.bytes[1] = cur_held[23:16];
                  bundle.bytes[2] = cur_held[15:8];
                  bundle.bytes[3] = cur_held[7:0];
                  bundle.bytes[4] = in_byte;
                  bundle.count    = CNT_W'(5);
               end else begin
                  bundle.bytes[0]   = '0;
                  bundle.count      = CNT_W'(1);
                  bundle.stream_end = 1'b1;
                  bundle.final_ts   = lo_ff[0];
               end
            end
         end
         PH_TS: begin
            if (cur_idx == IDX_W'(TS_LOW_BYTES)) begin
               bundle.bytes[0] = ts_out[23:16];
               bundle.bytes[1] = ts_out[15:8];
               bundle.bytes[2] = ts_out[7:0];
               bundle.bytes[3] = ts_out[31:24];
               bundle.count    = CNT_W'(4);
            end
         end
         PH_ENDED: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         idx_ff   <= '0;
         left_ff  <= '0;
         size_ff  <= '0;
         held_ff  <= '0;
         tag_ff   <= '0;
         tsacc_ff <= '0;
         first_ff <= '1;
         for (int s = 0; s < TIMED_STREAMS; s++) begin
            li_ff[s] <= '0;
            lo_ff[s] <= '0;
         end
      end else if (advance) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         left_ff  <= left_in;
         size_ff  <= size_in;
         held_ff  <= held_in;
         tag_ff   <= tag_in;
         tsacc_ff <= tsacc_in;
         first_ff <= first_in;
         for (int s = 0; s < TIMED_STREAMS; s++) begin
            li_ff[s] <= li_in[s];
            lo_ff[s] <= lo_in[s];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/flv_tag_timestamp_rewriter.sv @@
// ----------------------------------------------------------------------------
// FLV tag timestamp rewriter
// Rewrites the audio and video tag timestamps of an FLV byte stream.
// ----------------------------------------------------------------------------
// Bytes enter through an input register, are parsed combinationally, and their
// results (none, one, four or five bytes) go to a result register that drains
// one result per cycle while the output is not stalled. A one-result byte
// (header, size, stream id or payload) is then taken every cycle. The byte
// ending a tag prefix yields five results, the last timestamp byte four, sent
// in turn on the single result port as the next byte waits; these balance
// against the held prefix and timestamp bytes giving none, so the unstalled
// long-run rate is one byte per cycle. The configuration port is always ready.
`default_nettype none

module flv_tag_timestamp_rewriter
   import flvtsr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_start_of_file,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_stream_end,
   output logic [31:0]               rsp_final_audio_ts,
   output logic                      rsp_last_of_run,

   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_data
);

   cfg_type     cfg_ff;
   logic        pipe_valid_ff;
   logic [7:0]  pipe_byte_ff;
   logic        pipe_sof_ff;
   bundle_type  bundle;
   bundle_type  out_ff;
   logic        take;
   logic        load_ok;
   logic        advance;
   logic        load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fwd_limit  <= FWD_LIMIT_RESET;
         cfg_ff.back_limit <= BACK_LIMIT_RESET;
         cfg_ff.gap_step   <= GAP_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FWD_LIMIT:  cfg_ff.fwd_limit  <= csr_data;
            CSR_BACK_LIMIT: cfg_ff.back_limit <= csr_data;
            CSR_GAP_STEP:   cfg_ff.gap_step   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign take    = rsp_valid && !rsp_stall;
   // The result register can take a new run when empty or when its last result is being taken.
   assign load_ok = (out_ff.count == '0) || ((out_ff.count == CNT_W'(1)) && !rsp_stall);
   assign advance = pipe_valid_ff && ((bundle.count == '0) || load_ok);
   assign load    = pipe_valid_ff && (bundle.count != '0) && load_ok;
   assign req_stall = pipe_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         pipe_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         pipe_byte_ff <= req_in_byte;
         pipe_sof_ff  <= req_start_of_file;
      end
   end

   flvtsr_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_byte       (pipe_byte_ff),
      .start_of_file (pipe_sof_ff),
      .cfg           (cfg_ff),
      .bundle        (bundle)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.count <= '0;
      end else if (load) begin
         out_ff <= bundle;
      end else if (take) begin
         out_ff.count <= out_ff.count - 1'b1;
         out_ff.bytes <= {8'd0, out_ff.bytes[MAX_RESULTS-1:1]};
      end
   end

   assign rsp_valid          = (out_ff.count != '0);
   assign rsp_out_byte       = out_ff.bytes[0];
   assign rsp_byte_valid     = !out_ff.stream_end;
   assign rsp_stream_end     = out_ff.stream_end;
   assign rsp_final_audio_ts = out_ff.final_ts;
   assign rsp_last_of_run    = (out_ff.count == CNT_W'(1));

endmodule

`default_nettype wire
